[rtl/core/att_pkg.sv]
// ---------------------------------------------------------------------------
// att_pkg
// Shared types and codes for the allocation tracker table.
// ---------------------------------------------------------------------------
package att_pkg;

  localparam int ADDR_W  = 48;
  localparam int ERR_W   = 3;
  localparam int LIVE_OW = 9;

  typedef enum logic [1:0] {
    CMD_TRACK    = 2'd0,
    CMD_UNTRACK  = 2'd1,
    CMD_TRANSFER = 2'd2
  } cmd_e;

  localparam logic [ERR_W-1:0] ERR_OK           = 3'd0;
  localparam logic [ERR_W-1:0] ERR_HEAP_KNOWN   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNTRACKED    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_INPL_LAST    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_HEAP_ON_INPL = 3'd4;
  localparam logic [ERR_W-1:0] ERR_HEAP_NESTED  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_BAD_TRANSFER = 3'd6;
  localparam logic [ERR_W-1:0] ERR_TABLE_FULL   = 3'd7;

  localparam logic REG_ENABLED = 1'b0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic done;
    logic src_hit;
    logic tgt_hit;
    logic free_hit;
  } scan_flags_t;

endpackage

[rtl/core/att_scan.sv]
// ---------------------------------------------------------------------------
// att_scan
// Entry memory with a sequential sweep that finds the source entry, a
// distinct target entry and the lowest free slot.
// ---------------------------------------------------------------------------
module att_scan
  import att_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int COUNT_BITS    = 16,
  parameter int IDX_W         = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ADDR_W-1:0]     op_addr,
  input  logic [ADDR_W-1:0]     op_target,
  input  logic                  we,
  input  logic [IDX_W-1:0]      widx,
  input  logic                  wvalid,
  input  logic                  wheap,
  input  logic [COUNT_BITS-1:0] wcount,
  input  logic [ADDR_W-1:0]     waddr,
  output scan_flags_t           flags,
  output logic [IDX_W-1:0]      hit_idx,
  output logic [COUNT_BITS-1:0] hit_count,
  output logic                  hit_heap,
  output logic [IDX_W-1:0]      free_idx
);

  localparam int WORD_W = 2 + COUNT_BITS + ADDR_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [WORD_W-1:0] mem [TABLE_ENTRIES];
  logic [WORD_W-1:0] rd_q;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_busy;
  logic              cmp_v;
  logic              cmp_last;
  logic [IDX_W-1:0]  cmp_idx;

  logic                  q_valid;
  logic                  q_heap;
  logic [COUNT_BITS-1:0] q_count;
  logic [ADDR_W-1:0]     q_addr;
  logic                  m_src;
  logic                  m_tgt;

  assign {q_valid, q_heap, q_count, q_addr} = rd_q;
  assign m_src = q_valid && (q_addr == op_addr);
  assign m_tgt = q_valid && (q_addr == op_target) && (q_addr != op_addr);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= {wvalid, wheap, wcount, waddr};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_busy) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy  <= 1'b0;
      rd_idx   <= '0;
      cmp_v    <= 1'b0;
      cmp_last <= 1'b0;
      flags    <= '0;
    end else begin
      cmp_v      <= rd_busy;
      cmp_last   <= rd_busy && (rd_idx == LAST_IDX);
      flags.done <= cmp_v && cmp_last;
      if (start) begin
        rd_busy        <= 1'b1;
        rd_idx         <= '0;
        flags.src_hit  <= 1'b0;
        flags.tgt_hit  <= 1'b0;
        flags.free_hit <= 1'b0;
      end else if (rd_busy) begin
        if (rd_idx == LAST_IDX) begin
          rd_busy <= 1'b0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      if (cmp_v) begin
        if (m_src) begin
          flags.src_hit <= 1'b1;
        end
        if (m_tgt) begin
          flags.tgt_hit <= 1'b1;
        end
        if (!q_valid && !flags.free_hit) begin
          flags.free_hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx;
    if (cmp_v && m_src) begin
      hit_idx   <= cmp_idx;
      hit_count <= q_count;
      hit_heap  <= q_heap;
    end
    if (cmp_v && !q_valid && !flags.free_hit) begin
      free_idx <= cmp_idx;
    end
  end

endmodule

[rtl/core/allocation_tracker_table.sv]
// ---------------------------------------------------------------------------
// allocation_tracker_table
// Table of live addresses with nesting counts and origin flags; track,
// untrack and transfer commands with error reporting.
// ---------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | tdata: address, in_place, target_address; tuser: cmd
//  m_*      | out       | tdata: error_code, live_entries
//  apb      | in/out    | register 0 enabled at byte address 0
//
// an enabled command sweeps the whole entry memory, one read port entry
// per cycle, between accept and result.
// disabled or unused commands skip the sweep and go straight to the finish state.
// after reset a clearing pass over every entry runs before s_tready.
// a new transaction is taken while the previous result waits on m_tready;
// the result stage holds the next one until the output register frees up.
// ---------------------------------------------------------------------------
module allocation_tracker_table
  import att_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int COUNT_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,  // address[47:0], in_place[48], target_address[96:49], zero
  input  logic [1:0]   s_tuser,  // cmd[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,  // error_code[2:0], live_entries[11:3], zero
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int LIVE_W = $clog2(TABLE_ENTRIES + 1);
  localparam int EXT_W  = (LIVE_W > LIVE_OW) ? LIVE_W : LIVE_OW;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t state;
  state_t state_next;

  logic                  enabled;
  logic [IDX_W-1:0]      clear_idx;
  logic [LIVE_W-1:0]     live_total;
  logic [LIVE_W-1:0]     live_next;
  logic [EXT_W-1:0]      live_ext;

  logic [1:0]            op_cmd;
  logic [ADDR_W-1:0]     op_addr;
  logic                  op_inpl;
  logic [ADDR_W-1:0]     op_target;
  logic                  op_active;

  logic                  s_accept;
  logic                  in_active;
  logic                  out_free;
  logic                  finish;
  logic                  start;

  scan_flags_t           flags;
  logic [IDX_W-1:0]      hit_idx;
  logic [COUNT_BITS-1:0] hit_count;
  logic                  hit_heap;
  logic [IDX_W-1:0]      free_idx;

  logic [ERR_W-1:0]      err;
  logic                  upd_en;
  logic [IDX_W-1:0]      upd_idx;
  logic                  upd_valid;
  logic                  upd_heap;
  logic [COUNT_BITS-1:0] upd_count;
  logic [ADDR_W-1:0]     upd_addr;
  logic [COUNT_BITS-1:0] dec_count;

  logic                  we;
  logic [IDX_W-1:0]      widx;
  logic                  wvalid;
  logic                  wheap;
  logic [COUNT_BITS-1:0] wcount;
  logic [ADDR_W-1:0]     waddr;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_ENABLED) ? {31'b0, enabled} : 32'b0;
  assign s_accept  = s_tvalid && s_tready;
  assign in_active = enabled && ((s_tuser == CMD_TRACK) || (s_tuser == CMD_UNTRACK) ||
                                 (s_tuser == CMD_TRANSFER));
  assign out_free  = !m_tvalid || m_tready;
  assign live_ext  = EXT_W'(live_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ENABLED)) begin
      enabled <= pwdata[0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_accept) begin
          state_next = in_active ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (flags.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    start    = 1'b0;
    finish   = 1'b0;
    we       = 1'b0;
    widx     = upd_idx;
    wvalid   = upd_valid;
    wheap    = upd_heap;
    wcount   = upd_count;
    waddr    = upd_addr;
    unique case (state)
      ST_CLEAR: begin
        we     = 1'b1;
        widx   = clear_idx;
        wvalid = 1'b0;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        start    = s_accept && in_active;
      end
      ST_SCAN: begin
      end
      ST_FINISH: begin
        finish = out_free;
        we     = out_free && upd_en;
      end
      default: begin
      end
    endcase
  end

  // update of the matched or free entry
  always_comb begin
    err       = ERR_OK;
    live_next = live_total;
    upd_en    = 1'b0;
    upd_idx   = hit_idx;
    upd_valid = 1'b1;
    upd_heap  = hit_heap;
    upd_count = hit_count;
    upd_addr  = op_addr;
    dec_count = (hit_count != '0) ? hit_count - 1'b1 : hit_count;
    if (op_active) begin
      unique case (op_cmd)
        CMD_TRACK: begin
          if (!flags.src_hit) begin
            if (!flags.free_hit) begin
              err = ERR_TABLE_FULL;
            end else begin
              upd_en    = 1'b1;
              upd_idx   = free_idx;
              upd_heap  = !op_inpl;
              upd_count = COUNT_BITS'(1);
              live_next = live_total + 1'b1;
            end
          end else begin
            if (!op_inpl) begin
              err = ERR_HEAP_KNOWN;
            end
            upd_en = 1'b1;
            if (hit_count != '1) begin
              upd_count = hit_count + 1'b1;
            end
          end
        end
        CMD_UNTRACK: begin
          if (!flags.src_hit) begin
            err = ERR_UNTRACKED;
          end else begin
            if (hit_count == COUNT_BITS'(1)) begin
              if (op_inpl && hit_heap) begin
                err = ERR_INPL_LAST;
              end else if (!op_inpl && !hit_heap) begin
                err = ERR_HEAP_ON_INPL;
              end
            end else if (hit_count == COUNT_BITS'(2)) begin
              if (!op_inpl && hit_heap) begin
                err = ERR_HEAP_NESTED;
              end
            end
            upd_en    = 1'b1;
            upd_count = dec_count;
            if (dec_count == '0) begin
              upd_valid = 1'b0;
              if (live_total != '0) begin
                live_next = live_total - 1'b1;
              end
            end
          end
        end
        CMD_TRANSFER: begin
          if (flags.src_hit) begin
            if (hit_heap && (hit_count == COUNT_BITS'(1))) begin
              err = ERR_BAD_TRANSFER;
            end
            upd_en = 1'b1;
            if (flags.tgt_hit) begin
              upd_valid = 1'b0;
              if (live_total != '0) begin
                live_next = live_total - 1'b1;
              end
            end else begin
              upd_addr = op_target;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_idx  <= '0;
      live_total <= '0;
      m_tvalid   <= 1'b0;
      op_active  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_idx <= clear_idx + 1'b1;
      end
      if (s_accept) begin
        op_active <= in_active;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (finish) begin
        m_tvalid   <= 1'b1;
        live_total <= live_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      op_cmd    <= s_tuser;
      op_addr   <= s_tdata[47:0];
      op_inpl   <= s_tdata[48];
      op_target <= s_tdata[96:49];
    end
    if (finish) begin
      m_tdata <= {4'b0, live_ext[LIVE_OW-1:0], err};
    end
  end

  att_scan #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNT_BITS   (COUNT_BITS),
    .IDX_W        (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op_addr  (s_accept ? s_tdata[47:0] : op_addr),
    .op_target(s_accept ? s_tdata[96:49] : op_target),
    .we       (we),
    .widx     (widx),
    .wvalid   (wvalid),
    .wheap    (wheap),
    .wcount   (wcount),
    .waddr    (waddr),
    .flags    (flags),
    .hit_idx  (hit_idx),
    .hit_count(hit_count),
    .hit_heap (hit_heap),
    .free_idx (free_idx)
  );

endmodule

[verif/tb_allocation_tracker_table.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_allocation_tracker_table
// Self-checking bench for the allocation tracker table. Commands go in on
// the s_* stream in random bursts and results are pulled from the m_* stream
// under a random stall pattern. A scoreboard keeps its own copy of the table
// and predicts error code and live count for every accepted command. The run
// covers the disabled mode, every error rule, count saturation (the count
// width is reduced so that it can be reached), a full table and a long
// random mix over a small address pool.
// ---------------------------------------------------------------------------
module tb_allocation_tracker_table;
  import att_pkg::*;

  localparam int TABLE_N   = 256;
  localparam int CNT_BITS  = 4;
  localparam int POOL_N    = 16;
  localparam int LIMIT     = 5000000;

  localparam logic [1:0]        CMD_UNUSED  = 2'd3;
  localparam logic [2:0]        ENABLE_ADDR = {REG_ENABLED, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_ONES   = '1;
  localparam logic [ADDR_W-1:0] ADDR_ZERO   = '0;

  typedef struct {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic              in_place;
    logic [ADDR_W-1:0] target;
  } alloc_cmd_t;

  typedef struct {
    logic [ERR_W-1:0]   err;
    logic [LIVE_OW-1:0] live;
  } alloc_result_t;

  class alloc_scoreboard;
    bit                  enabled;
    bit [ADDR_W-1:0]     ent_addr [TABLE_N];
    bit                  ent_valid [TABLE_N];
    bit [CNT_BITS-1:0]   ent_cnt [TABLE_N];
    bit                  ent_heap [TABLE_N];
    int unsigned         live;
    alloc_result_t       pending [$];
    int unsigned         mismatches;

    function int find_addr(logic [ADDR_W-1:0] a, int skip);
      for (int k = 0; k < TABLE_N; k++)
        if (k != skip && ent_valid[k] && ent_addr[k] == a) return k;
      return -1;
    endfunction

    function int find_free();
      for (int k = 0; k < TABLE_N; k++)
        if (!ent_valid[k]) return k;
      return -1;
    endfunction

    function void free_slot(int k);
      ent_valid[k] = 1'b0;
      if (live > 0) live--;
    endfunction

    function logic [ERR_W-1:0] do_track(logic [ADDR_W-1:0] a, logic inpl);
      int k;
      k = find_addr(a, -1);
      if (k < 0) begin
        k = find_free();
        if (k < 0) return ERR_TABLE_FULL;
        ent_valid[k] = 1'b1;
        ent_addr[k]  = a;
        ent_cnt[k]   = CNT_BITS'(1);
        ent_heap[k]  = !inpl;
        live++;
        return ERR_OK;
      end
      if (ent_cnt[k] != '1) ent_cnt[k]++;
      return inpl ? ERR_OK : ERR_HEAP_KNOWN;
    endfunction

    function logic [ERR_W-1:0] do_untrack(logic [ADDR_W-1:0] a, logic inpl);
      int k;
      logic [ERR_W-1:0] err;
      k = find_addr(a, -1);
      err = ERR_OK;
      if (k < 0) return ERR_UNTRACKED;
      if (ent_cnt[k] == 1) begin
        if (inpl && ent_heap[k]) err = ERR_INPL_LAST;
        else if (!inpl && !ent_heap[k]) err = ERR_HEAP_ON_INPL;
      end else if (ent_cnt[k] == 2) begin
        if (!inpl && ent_heap[k]) err = ERR_HEAP_NESTED;
      end
      if (ent_cnt[k] != 0) ent_cnt[k]--;
      if (ent_cnt[k] == 0) free_slot(k);
      return err;
    endfunction

    function logic [ERR_W-1:0] do_transfer(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst);
      int k;
      logic [ERR_W-1:0] err;
      k = find_addr(src, -1);
      err = ERR_OK;
      if (k < 0) return ERR_OK;
      if (ent_heap[k] && ent_cnt[k] == 1) err = ERR_BAD_TRANSFER;
      if (find_addr(dst, k) >= 0) free_slot(k);
      else ent_addr[k] = dst;
      return err;
    endfunction

    function void note_input(alloc_cmd_t c);
      alloc_result_t r;
      r.err = ERR_OK;
      if (enabled) begin
        case (c.cmd)
          CMD_TRACK:    r.err = do_track(c.addr, c.in_place);
          CMD_UNTRACK:  r.err = do_untrack(c.addr, c.in_place);
          CMD_TRANSFER: r.err = do_transfer(c.addr, c.target);
          default:      r.err = ERR_OK;
        endcase
      end
      r.live = LIVE_OW'(live);
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [ERR_W-1:0] err, logic [LIVE_OW-1:0] lv);
      alloc_result_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result err %0d live %0d", err, lv));
        return;
      end
      e = pending.pop_front();
      if (err !== e.err) report($sformatf("error_code %0d, expected %0d", err, e.err));
      if (lv !== e.live) report($sformatf("live_entries %0d, expected %0d", lv, e.live));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;  // address[47:0], in_place[48], target_address[96:49], zero
  logic [1:0]   s_tuser = '0;  // cmd[1:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;       // error_code[2:0], live_entries[11:3], zero
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  alloc_scoreboard sb;

  logic [ADDR_W-1:0] pool [POOL_N];
  logic [ADDR_W-1:0] fill_addrs [$];
  int unsigned       burst_left = 0;
  int unsigned       cycles = 0;
  int unsigned       rx_count = 0;
  int unsigned       rx_mode = 0;
  logic [31:0]       rx_bits = '1;

  allocation_tracker_table #(
    .TABLE_ENTRIES(TABLE_N),
    .COUNT_BITS   (CNT_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_allocation_tracker_table: errors");
      $finish;
    end
  end

  // receiver stall pattern, reloaded with a new random mode once all bits of rx_bits are used
  always @(posedge clk) begin
    if (rx_count == 0) begin
      rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       rx_bits = '1;
        1:       rx_bits = $urandom;
        2:       rx_bits = $urandom & $urandom;
        default: rx_bits = $urandom | $urandom;
      endcase
      rx_count = 32;
    end
    rx_count = rx_count - 1;
    m_tready <= rx_bits[rx_count[4:0]];
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[2:0], m_tdata[11:3]);
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  task automatic issue(input logic [1:0] cmd, input logic [ADDR_W-1:0] a,
                       input logic inpl, input logic [ADDR_W-1:0] t);
    alloc_cmd_t c;
    int unsigned gap;
    c.cmd = cmd;
    c.addr = a;
    c.in_place = inpl;
    c.target = t;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      case ($urandom_range(0, 19))
        0:       gap = $urandom_range(200, 320);
        1, 2, 3: gap = $urandom_range(5, 40);
        default: gap = $urandom_range(1, 4);
      endcase
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, t, inpl, a};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(c);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ENABLE_ADDR) sb.enabled = data[0];
  endtask

  task automatic random_run(input int n);
    int unsigned pick;
    logic [1:0] cmd;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] t;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_TRACK;
      else if (pick < 72) cmd = CMD_UNTRACK;
      else if (pick < 94) cmd = CMD_TRANSFER;
      else cmd = CMD_UNUSED;
      a = ($urandom_range(0, 9) == 0) ? rand_addr() : pool[$urandom_range(0, POOL_N - 1)];
      t = ($urandom_range(0, 2) == 0) ? rand_addr() : pool[$urandom_range(0, POOL_N - 1)];
      issue(cmd, a, 1'($urandom_range(0, 1)), t);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] a;
    sb = new();
    pool[0] = ADDR_ONES;
    pool[1] = ADDR_ZERO;
    for (int k = 2; k < POOL_N; k++) pool[k] = rand_addr();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);

    // disabled after reset: everything is a no-op
    issue(CMD_TRACK, ADDR_ONES, 1'b0, ADDR_ZERO);
    issue(CMD_UNTRACK, ADDR_ONES, 1'b1, ADDR_ONES);
    issue(CMD_TRANSFER, ADDR_ZERO, 1'b0, ADDR_ONES);
    issue(CMD_UNUSED, ADDR_ONES, 1'b1, ADDR_ONES);
    wait_idle();
    apb_write(ENABLE_ADDR, 32'd1);

    // error rules on nesting and origin
    issue(CMD_TRACK, ADDR_ONES, 1'b0, ADDR_ZERO);
    issue(CMD_TRACK, ADDR_ONES, 1'b0, ADDR_ZERO);
    issue(CMD_UNTRACK, ADDR_ONES, 1'b0, ADDR_ZERO);
    issue(CMD_UNTRACK, ADDR_ONES, 1'b1, ADDR_ZERO);
    issue(CMD_UNTRACK, ADDR_ONES, 1'b0, ADDR_ZERO);
    issue(CMD_TRACK, ADDR_ZERO, 1'b1, ADDR_ONES);
    issue(CMD_UNTRACK, ADDR_ZERO, 1'b0, ADDR_ONES);
    issue(CMD_TRACK, pool[2], 1'b1, ADDR_ZERO);
    issue(CMD_TRACK, pool[2], 1'b0, ADDR_ZERO);
    issue(CMD_UNTRACK, pool[2], 1'b0, ADDR_ZERO);
    issue(CMD_UNTRACK, pool[2], 1'b1, ADDR_ZERO);
    // transfers: unknown source, move, onto existing target, onto itself
    issue(CMD_TRANSFER, pool[3], 1'b0, pool[4]);
    issue(CMD_TRACK, pool[3], 1'b0, ADDR_ZERO);
    issue(CMD_TRANSFER, pool[3], 1'b0, pool[4]);
    issue(CMD_TRACK, pool[5], 1'b1, ADDR_ZERO);
    issue(CMD_TRANSFER, pool[4], 1'b1, pool[5]);
    issue(CMD_TRANSFER, pool[5], 1'b0, pool[5]);
    issue(CMD_TRANSFER, pool[5], 1'b0, ADDR_ONES);
    issue(CMD_UNTRACK, ADDR_ONES, 1'b1, ADDR_ZERO);
    issue(CMD_UNTRACK, pool[5], 1'b1, ADDR_ZERO);
    issue(CMD_UNUSED, ADDR_ONES, 1'b1, ADDR_ONES);
    // count saturation
    for (int k = 0; k < (1 << CNT_BITS) + 1; k++) issue(CMD_TRACK, pool[6], 1'b1, ADDR_ZERO);
    issue(CMD_TRACK, pool[6], 1'b0, ADDR_ZERO);

    // fill the table, overflow it, then drain the fill entries
    while (sb.live < TABLE_N) begin
      a = rand_addr();
      fill_addrs.push_back(a);
      issue(CMD_TRACK, a, 1'($urandom_range(0, 1)), ADDR_ZERO);
    end
    issue(CMD_TRACK, rand_addr(), 1'b0, ADDR_ZERO);
    issue(CMD_TRACK, rand_addr(), 1'b1, ADDR_ZERO);
    issue(CMD_TRACK, pool[6], 1'b0, ADDR_ZERO);
    issue(CMD_TRANSFER, fill_addrs[0], 1'b0, rand_addr());
    issue(CMD_TRACK, rand_addr(), 1'b0, ADDR_ZERO);
    while (fill_addrs.size() != 0) begin
      a = fill_addrs.pop_front();
      issue(CMD_UNTRACK, a, 1'($urandom_range(0, 1)), ADDR_ZERO);
    end

    random_run(600);
    wait_idle();
    apb_write(ENABLE_ADDR, 32'd0);
    random_run(100);
    wait_idle();
    apb_write(ENABLE_ADDR, 32'd1);
    random_run(300);

    wait_idle();
    repeat (TABLE_N + 16) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.mismatches == 0) begin
      $display("tb_allocation_tracker_table: clean");
    end else begin
      $display("tb_allocation_tracker_table: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/att_pkg.sv
rtl/core/att_scan.sv
rtl/core/allocation_tracker_table.sv
verif/tb_allocation_tracker_table.sv
